>>> rtl/core/cpa_pkg.sv
// ----------------------------------------------------------------------------
// Contiguous page allocator package
// Shared field widths, command and status codes, descriptor flag bits and register indices.
// ----------------------------------------------------------------------------
package cpa_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned CountW = 11;
  localparam int unsigned StatW  = 2;
  localparam int unsigned FlagW  = 2;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD      = 2'd2
  } status_e;

  localparam int unsigned FlagTakenBit = 0;
  localparam int unsigned FlagLastBit  = 1;

  typedef logic [FlagW-1:0] flags_t;

  localparam flags_t FlagNone  = 2'b00;
  localparam flags_t FlagTaken = 2'b01;
  localparam flags_t FlagLast  = 2'b10;

  typedef enum logic [0:0] {
    REG_HEAP_BASE  = 1'b0,
    REG_PAGE_TOTAL = 1'b1
  } reg_idx_e;

endpackage

>>> rtl/core/cpa_if.sv
// ----------------------------------------------------------------------------
// Contiguous page allocator channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
interface cpa_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [10:0] page_count;
  logic [31:0] address;

  modport source (output valid, command, page_count, address, input ready);
  modport sink   (input valid, command, page_count, address, output ready);
endinterface

interface cpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_address;
  logic [1:0]  status;

  modport source (output valid, block_address, status, input ready);
  modport sink   (input valid, block_address, status, output ready);
endinterface

>>> rtl/core/contiguous_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// Contiguous page allocator unit
// First-fit allocator over a ring of page descriptor cells.
// ----------------------------------------------------------------------------
// A request transaction carries a command (allocate or free), a page count
// and an address; each one yields exactly one response transaction with a
// block address and a status. heap_base and page_total must be written over
// the APB port only while the unit is idle; the unit does not enforce this.
// The descriptors sit in a ring of MAX_PAGES cells that rotates by one cell
// per cycle past a single inspection point while a request is in progress.
// An allocation takes one search pass and, if a run is found, one marking
// pass. A free takes one pass. Bad requests and oversized counts answer
// with a response registered in the cycle after acceptance.
// One request is handled at a time; a new request is taken once the previous
// response has left the output register. When the receiver stalls, the
// response is held and no further request is taken.
// Reset clears every descriptor and both registers at once.
// ----------------------------------------------------------------------------
module contiguous_page_allocator_unit #(
  parameter int unsigned MAX_PAGES  = 1024,
  parameter int unsigned PAGE_SHIFT = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cpa_req_if.sink      req_i,
  cpa_rsp_if.source    rsp_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import cpa_pkg::*;

  localparam int unsigned IdxW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned RunW = $clog2(MAX_PAGES + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_PAGES - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_MARK   = 4'b0100,
    S_FREE   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [31:0]       heap_base_q;
  logic [10:0]       page_total_q;
  logic [IdxW-1:0]   ctr_q, ctr_d;
  logic [RunW-1:0]   run_q, run_d;
  logic              found_q, found_d;
  logic              walk_q, walk_d;
  logic [IdxW-1:0]   start_q, start_d;
  logic [IdxW-1:0]   end_q, end_d;
  logic [10:0]       count_q, count_d;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_addr_q, out_addr_d;
  logic [1:0]        out_stat_q, out_stat_d;

  flags_t            ring [MAX_PAGES];
  flags_t            head, tail;
  logic              shift;

  logic [31:0]       managed;
  logic [31:0]       offset;
  logic [31:0]       off_idx;
  logic              free_bad;
  logic              req_fire;
  logic              ctr_in_range;
  logic              at_end;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PAGE_TOTAL) ? {21'd0, page_total_q} : heap_base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      page_total_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_PAGE_TOTAL) begin
        page_total_q <= pwdata[10:0];
      end else begin
        heap_base_q <= pwdata;
      end
    end
  end

  assign shift = (state_q != S_IDLE);
  assign head  = ring[0];

  for (genvar k = 0; k < MAX_PAGES; k++) begin : g_cell
    flags_t nxt;
    if (k == MAX_PAGES - 1) begin : g_tail
      assign nxt = tail;
    end else begin : g_mid
      assign nxt = ring[k+1];
    end
    cpa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .flags_i (nxt),
      .flags_o (ring[k])
    );
  end

  assign managed  = (32'(page_total_q) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES)
                                                         : 32'(page_total_q);
  assign offset   = req_i.address - heap_base_q;
  assign off_idx  = offset >> PAGE_SHIFT;
  assign free_bad = (req_i.address == 32'd0) || (req_i.address < heap_base_q) ||
                    ((offset & ((32'd1 << PAGE_SHIFT) - 32'd1)) != 32'd0) ||
                    (off_idx >= managed);

  assign req_i.ready   = (state_q == S_IDLE) && !out_valid_q;
  assign req_fire      = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.block_address = out_addr_q;
  assign rsp_o.status  = out_stat_q;

  assign ctr_in_range = 32'(ctr_q) < managed;
  assign at_end       = (ctr_q == LastIdx);

  always_comb begin
    state_d     = state_q;
    ctr_d       = ctr_q;
    run_d       = run_q;
    found_d     = found_q;
    walk_d      = walk_q;
    start_d     = start_q;
    end_d       = end_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_stat_d  = out_stat_q;
    tail        = head;

    if (rsp_o.valid && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          ctr_d   = '0;
          run_d   = '0;
          found_d = 1'b0;
          count_d = req_i.page_count;
          if (req_i.command == CMD_ALLOC) begin
            if (req_i.page_count == 11'd0) begin
              out_valid_d = 1'b1;
              out_addr_d  = '0;
              out_stat_d  = ST_BAD;
            end else if (32'(req_i.page_count) > managed) begin
              out_valid_d = 1'b1;
              out_addr_d  = '0;
              out_stat_d  = ST_NO_SPACE;
            end else begin
              state_d = S_SEARCH;
            end
          end else begin
            if (free_bad) begin
              out_valid_d = 1'b1;
              out_addr_d  = '0;
              out_stat_d  = ST_BAD;
            end else begin
              start_d = IdxW'(off_idx);
              walk_d  = 1'b1;
              state_d = S_FREE;
            end
          end
        end
      end
      S_SEARCH: begin
        if (ctr_in_range && !found_q) begin
          if (head[FlagTakenBit]) begin
            run_d = '0;
          end else begin
            run_d = run_q + RunW'(1);
            if (32'(run_q) + 32'd1 == 32'(count_q)) begin
              found_d = 1'b1;
              end_d   = ctr_q;
              start_d = IdxW'(32'(ctr_q) + 32'd1 - 32'(count_q));
            end
          end
        end
        ctr_d = at_end ? '0 : ctr_q + IdxW'(1);
        if (at_end) begin
          if (found_d) begin
            state_d = S_MARK;
          end else begin
            state_d     = S_IDLE;
            out_valid_d = 1'b1;
            out_addr_d  = '0;
            out_stat_d  = ST_NO_SPACE;
          end
        end
      end
      S_MARK: begin
        if (ctr_q >= start_q && ctr_q <= end_q) begin
          tail = (ctr_q == end_q) ? (FlagTaken | FlagLast) : FlagTaken;
        end
        ctr_d = at_end ? '0 : ctr_q + IdxW'(1);
        if (at_end) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          out_addr_d  = heap_base_q + (32'(start_q) << PAGE_SHIFT);
          out_stat_d  = ST_OK;
        end
      end
      S_FREE: begin
        if (walk_q && ctr_q >= start_q) begin
          if (head[FlagTakenBit]) begin
            tail = FlagNone;
            if (head[FlagLastBit]) begin
              walk_d = 1'b0;
            end
          end else begin
            walk_d = 1'b0;
          end
        end
        ctr_d = at_end ? '0 : ctr_q + IdxW'(1);
        if (at_end) begin
          state_d     = S_IDLE;
          walk_d      = 1'b0;
          out_valid_d = 1'b1;
          out_addr_d  = '0;
          out_stat_d  = ST_OK;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ctr_q       <= '0;
      run_q       <= '0;
      found_q     <= 1'b0;
      walk_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      run_q       <= run_d;
      found_q     <= found_d;
      walk_q      <= walk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q    <= start_d;
    end_q      <= end_d;
    count_q    <= count_d;
    out_addr_q <= out_addr_d;
    out_stat_q <= out_stat_d;
  end

endmodule

>>> rtl/core/cpa_cell.sv
// ----------------------------------------------------------------------------
// Page descriptor cell
// Holds the flags of one page and takes its neighbour's flags on each shift.
// ----------------------------------------------------------------------------
module cpa_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            shift_i,
  input  cpa_pkg::flags_t flags_i,
  output cpa_pkg::flags_t flags_o
);
  import cpa_pkg::*;

  flags_t flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= FlagNone;
    end else if (shift_i) begin
      flags_q <= flags_i;
    end
  end

  assign flags_o = flags_q;

endmodule
